### rtl/nbrf_pkg.sv
// shared constants for the nine-bit receive filter fifo
// no dependencies; compiled first
`default_nettype none

package nbrf_pkg;

	localparam int unsigned OP_W           = 2;
	localparam int unsigned WORD_W         = 9;
	localparam int unsigned FIFO_DEPTH_DEF = 32;

	// event codes on the request opcode field
	localparam logic [OP_W-1:0] OP_RX_WORD = 2'd0;
	localparam logic [OP_W-1:0] OP_CMD_TX  = 2'd1;
	localparam logic [OP_W-1:0] OP_POP     = 2'd2;

	// word that forces parity odd outside an acknowledge wait
	localparam logic [WORD_W-1:0] ACK_WORD = 9'h121;

endpackage

`default_nettype wire

### rtl/nbrf_if.sv
// request and response channel interfaces for the receive filter fifo
// depends on nbrf_pkg
`default_nettype none

interface nbrf_req_if;
	import nbrf_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [WORD_W-1:0] bus_word;

	modport source (output valid, output opcode, output bus_word, input ready);
	modport sink   (input valid, input opcode, input bus_word, output ready);
endinterface

interface nbrf_rsp_if;
	import nbrf_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] read_word;
	logic              read_valid;
	logic              words_available;
	logic              dropped_full;

	modport source (output valid, output read_word, output read_valid,
		output words_available, output dropped_full, input ready);
	modport sink   (input valid, input read_word, input read_valid,
		input words_available, input dropped_full, output ready);
endinterface

`default_nettype wire

### rtl/nine_bit_rx_filter_fifo.sv
// nine-bit receive filter feeding a ring fifo, one request in, one response out
// response valid is registered, in the cycle after the request is accepted
// throughput: one request per cycle; a response waiting in the output
//   register does not block the next request while the sink is ready
// reset: arst_n clears the acknowledge wait, parity, pointers, fill level and
//   output valid; fifo storage is not cleared and only written entries are read
// depends on nbrf_pkg and nbrf_if
`default_nettype none

module nine_bit_rx_filter_fifo #(
	parameter int unsigned FIFO_DEPTH = nbrf_pkg::FIFO_DEPTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	nbrf_req_if.sink     req,
	nbrf_rsp_if.source   rsp
);
	import nbrf_pkg::*;

	localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	// word storage, written on push, read into the output stage on pop
	logic [WORD_W-1:0] mem [FIFO_DEPTH];

	// control state
	logic             ack_pending_q;
	logic             zero_parity_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	// output stage
	logic              valid_s1;
	logic [WORD_W-1:0] rdata_s1;
	logic              read_valid_s1;
	logic              words_avail_s1;
	logic              dropped_s1;

	// request decode
	logic             accept;
	logic             is_rx;
	logic             is_cmd;
	logic             is_pop;
	logic             word_nonzero;
	logic             parity_next;
	logic             store_want;
	logic             fifo_full;
	logic             fifo_empty;
	logic             do_push;
	logic             do_pop;
	logic             dropped;
	logic [CNT_W-1:0] fill_next;

	// output register frees up when empty or being taken this cycle
	assign req.ready = !valid_s1 || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign is_rx  = (req.opcode == OP_RX_WORD);
	assign is_cmd = (req.opcode == OP_CMD_TX);
	assign is_pop = (req.opcode == OP_POP);

	assign word_nonzero = (req.bus_word != '0);
	assign fifo_full    = (fill_q == CNT_W'(FIFO_DEPTH));
	assign fifo_empty   = (fill_q == '0);

	always_comb begin
		// parity only moves on words outside an acknowledge wait
		parity_next = zero_parity_q;
		store_want  = 1'b0;
		if (is_rx) begin
			if (ack_pending_q) begin
				// acknowledge word: zero is the bare ack and is discarded
				store_want = word_nonzero;
			end else begin
				if (req.bus_word == ACK_WORD) begin
					parity_next = 1'b1;
				end else begin
					parity_next = !zero_parity_q;
				end
				// a zero word is real data only when the updated parity is odd
				store_want = word_nonzero || parity_next;
			end
		end
	end

	assign do_push = accept && store_want && !fifo_full;
	assign dropped = store_want && fifo_full;
	assign do_pop  = accept && is_pop && !fifo_empty;

	always_comb begin
		fill_next = fill_q;
		if (do_push) begin
			fill_next = fill_q + CNT_W'(1);
		end else if (do_pop) begin
			fill_next = fill_q - CNT_W'(1);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_pending_q <= 1'b0;
			zero_parity_q <= 1'b0;
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			fill_q        <= '0;
			valid_s1      <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (is_cmd) begin
					ack_pending_q <= 1'b1;
				end else if (is_rx) begin
					ack_pending_q <= 1'b0;
				end
				if (is_rx && !ack_pending_q) begin
					zero_parity_q <= parity_next;
				end
			end else if (rsp.ready) begin
				valid_s1 <= 1'b0;
			end
			// pointers wrap at the fifo depth, which need not be a power of two
			if (do_push) begin
				if (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + PTR_W'(1);
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PTR_W'(1);
				end
			end
			fill_q <= fill_next;
		end
	end

	// storage write port
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= req.bus_word;
		end
	end

	// storage read port, registered; holds while the response is stalled
	always_ff @(posedge clk) begin
		if (do_pop) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	// response flags, loaded with each accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			read_valid_s1  <= do_pop;
			words_avail_s1 <= (fill_next != '0);
			dropped_s1     <= dropped;
		end
	end

	// read word reads as zero unless this response carries a popped word
	assign rsp.valid           = valid_s1;
	assign rsp.read_word       = read_valid_s1 ? rdata_s1 : '0;
	assign rsp.read_valid      = read_valid_s1;
	assign rsp.words_available = words_avail_s1;
	assign rsp.dropped_full    = dropped_s1;

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// self-checking bench for nine_bit_rx_filter_fifo: directed table, then random traffic
// depends on nbrf_pkg, nbrf_if and the rtl top level

module tb;
	import nbrf_pkg::*;

	// opcode value the block must ignore
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned RANDOM_REQUESTS = 1900;
	localparam int unsigned DIRECTED_ROWS = 25;

	typedef struct packed {
		logic [WORD_W-1:0] read_word;
		logic              read_valid;
		logic              words_available;
		logic              dropped_full;
	} rx_rsp_t;

	// one row of the directed table; fixed_rsp is used only when has_fixed is set
	typedef struct {
		logic [OP_W-1:0]   op;
		logic [WORD_W-1:0] word;
		bit                has_fixed;
		rx_rsp_t           fixed_rsp;
	} rx_step_t;

	logic clk;
	logic arst_n;

	nbrf_req_if req_ch ();
	nbrf_rsp_if rsp_ch ();

	nine_bit_rx_filter_fifo u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// mirror of the block state
	logic              ack_wait;
	logic              zero_odd;
	logic [WORD_W-1:0] stored_words [$];

	// responses still owed by the block, oldest first
	rx_rsp_t     owed_responses [$];
	int unsigned mismatches;
	int unsigned burst_left;
	rx_step_t    directed_steps [DIRECTED_ROWS];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

	// filter and fifo update for one accepted request, returns the response it owes
	function automatic rx_rsp_t filter_rx_event(input logic [OP_W-1:0] op,
		input logic [WORD_W-1:0] word);
		rx_rsp_t r;
		bit      keep;
		r = '0;
		keep = 1'b0;
		case (op)
		OP_RX_WORD: begin
			if (ack_wait) begin
				// acknowledge slot: zero means no ack, drop it
				ack_wait = 1'b0;
				keep = (word != '0);
			end else begin
				if (word == ACK_WORD) begin
					zero_odd = 1'b1;
				end else begin
					zero_odd = ~zero_odd;
				end
				keep = (word != '0) || zero_odd;
			end
			if (keep) begin
				if (stored_words.size() >= FIFO_DEPTH_DEF) begin
					r.dropped_full = 1'b1;
				end else begin
					stored_words.push_back(word);
				end
			end
		end
		OP_CMD_TX: begin
			ack_wait = 1'b1;
		end
		OP_POP: begin
			if (stored_words.size() > 0) begin
				r.read_word = stored_words.pop_front();
				r.read_valid = 1'b1;
			end
		end
		default: begin
		end
		endcase
		r.words_available = (stored_words.size() > 0);
		return r;
	endfunction

	// drives one request, waits for its handshake and records what it owes
	task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
		input bit has_fixed, input rx_rsp_t fixed_rsp);
		int unsigned gap;
		rx_rsp_t     predicted;
		if (burst_left == 0) begin
			// a quarter of the bursts follow the last one back to back
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid    <= 1'b1;
		req_ch.opcode   <= op;
		req_ch.bus_word <= word;
		// handshake is judged mid-cycle, the request is taken at the next rising edge
		do begin
			@(negedge clk);
		end while (!req_ch.ready);
		predicted = filter_rx_event(op, word);
		owed_responses.push_back(has_fixed ? fixed_rsp : predicted);
		@(posedge clk);
	endtask

	// response side: stall pattern changes every window
	initial begin
		int unsigned window_left;
		int unsigned stall_mode;
		logic [7:0]  stall_mask;
		int unsigned phase;
		window_left = 0;
		stall_mode = 0;
		stall_mask = '0;
		phase = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (window_left == 0) begin
				window_left = $urandom_range(16, 80);
				stall_mode = $urandom_range(0, 2);
				stall_mask = 8'($urandom_range(1, 255));
			end
			window_left--;
			phase++;
			case (stall_mode)
			0: begin
				rsp_ch.ready <= 1'b1;
			end
			1: begin
				rsp_ch.ready <= stall_mask[3'(phase)];
			end
			default: begin
				rsp_ch.ready <= ($urandom_range(0, 9) > 3);
			end
			endcase
		end
	end

	// response checker, compares every accepted response with the oldest owed one
	always @(negedge clk) begin
		rx_rsp_t want;
		rx_rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.read_word, rsp_ch.read_valid, rsp_ch.words_available,
				rsp_ch.dropped_full};
			if (owed_responses.size() == 0) begin
				$error("response with none owed: word %h valid %b avail %b drop %b",
					got.read_word, got.read_valid, got.words_available, got.dropped_full);
				mismatches++;
			end else begin
				want = owed_responses.pop_front();
				if (got.read_word !== want.read_word) begin
					$error("read_word expected %h got %h", want.read_word, got.read_word);
					mismatches++;
				end
				if (got.read_valid !== want.read_valid) begin
					$error("read_valid expected %b got %b", want.read_valid, got.read_valid);
					mismatches++;
				end
				if (got.words_available !== want.words_available) begin
					$error("words_available expected %b got %b", want.words_available,
						got.words_available);
					mismatches++;
				end
				if (got.dropped_full !== want.dropped_full) begin
					$error("dropped_full expected %b got %b", want.dropped_full,
						got.dropped_full);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned      random_sent;
		int unsigned      seg_left;
		int unsigned      traffic_mode;
		int unsigned      pick;
		int unsigned      rx_cut;
		int unsigned      cmd_cut;
		int unsigned      word_kind;
		logic [OP_W-1:0]  op;
		logic [WORD_W-1:0] word;

		ack_wait = 1'b0;
		zero_odd = 1'b0;
		mismatches = 0;
		burst_left = 0;
		arst_n = 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.opcode   <= OP_RX_WORD;
		req_ch.bus_word <= '0;

		// directed table; fixed responses are the ones obvious from the spec
		directed_steps = '{
			// pop right after reset: nothing stored
			'{OP_POP,     9'h000, 1'b1, '{9'h000, 1'b0, 1'b0, 1'b0}},
			// unused opcode is ignored
			'{OP_UNUSED,  9'h1ff, 1'b1, '{9'h000, 1'b0, 1'b0, 1'b0}},
			// first zero makes parity odd and is kept
			'{OP_RX_WORD, 9'h000, 1'b1, '{9'h000, 1'b0, 1'b1, 1'b0}},
			// second zero makes parity even and is filtered
			'{OP_RX_WORD, 9'h000, 1'b1, '{9'h000, 1'b0, 1'b1, 1'b0}},
			'{OP_POP,     9'h000, 1'b1, '{9'h000, 1'b1, 1'b0, 1'b0}},
			'{OP_RX_WORD, 9'h1ff, 1'b0, '0},
			// ack word forces parity odd
			'{OP_RX_WORD, ACK_WORD, 1'b0, '0},
			'{OP_RX_WORD, 9'h000, 1'b0, '0},
			'{OP_RX_WORD, 9'h000, 1'b0, '0},
			// command while already armed stays armed
			'{OP_CMD_TX,  9'h1ff, 1'b0, '0},
			'{OP_CMD_TX,  9'h000, 1'b0, '0},
			// zero in the ack slot is dropped and clears the wait
			'{OP_RX_WORD, 9'h000, 1'b0, '0},
			'{OP_RX_WORD, 9'h000, 1'b0, '0},
			'{OP_CMD_TX,  9'h155, 1'b0, '0},
			// nonzero ack with only the ninth bit set
			'{OP_RX_WORD, 9'h100, 1'b0, '0},
			'{OP_CMD_TX,  9'h0aa, 1'b0, '0},
			// ack word in the ack slot leaves parity alone
			'{OP_RX_WORD, ACK_WORD, 1'b0, '0},
			'{OP_POP,     9'h1ff, 1'b0, '0},
			'{OP_POP,     9'h000, 1'b0, '0},
			'{OP_POP,     9'h000, 1'b0, '0},
			'{OP_POP,     9'h000, 1'b0, '0},
			'{OP_POP,     9'h000, 1'b0, '0},
			// drained again: empty pop
			'{OP_POP,     9'h000, 1'b1, '{9'h000, 1'b0, 1'b0, 1'b0}},
			'{OP_RX_WORD, 9'h155, 1'b0, '0},
			'{OP_RX_WORD, 9'h0aa, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			send_request(directed_steps[i].op, directed_steps[i].word,
				directed_steps[i].has_fixed, directed_steps[i].fixed_rsp);
		end

		// random traffic in segments: fill-heavy, drain-heavy or balanced;
		// the first segment fills so the full-fifo drop is reached early
		random_sent = 0;
		traffic_mode = 0;
		seg_left = 120;
		while (random_sent < RANDOM_REQUESTS) begin
			if (seg_left == 0) begin
				traffic_mode = $urandom_range(0, 2);
				seg_left = $urandom_range(32, 96);
			end
			seg_left--;
			case (traffic_mode)
			0: begin
				rx_cut = 80;
				cmd_cut = 90;
			end
			1: begin
				rx_cut = 20;
				cmd_cut = 30;
			end
			default: begin
				rx_cut = 45;
				cmd_cut = 60;
			end
			endcase
			// received word: zeros and the ack word are frequent so parity gets exercised
			word_kind = $urandom_range(0, 9);
			if (word_kind < 3) begin
				word = '0;
			end else if (word_kind == 3) begin
				word = ACK_WORD;
			end else if (word_kind == 4) begin
				word = '1;
			end else begin
				word = WORD_W'($urandom_range(0, 511));
			end
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				op = OP_UNUSED;
			end else if (pick < rx_cut) begin
				op = OP_RX_WORD;
			end else if (pick < cmd_cut) begin
				op = OP_CMD_TX;
			end else begin
				op = OP_POP;
			end
			send_request(op, word, 1'b0, '0);
			if (op != OP_UNUSED) begin
				random_sent++;
			end
			// a command is mostly followed by its acknowledge slot
			if (op == OP_CMD_TX && $urandom_range(0, 3) != 0) begin
				word = ($urandom_range(0, 2) == 0) ? '0 : WORD_W'($urandom_range(0, 511));
				send_request(OP_RX_WORD, word, 1'b0, '0);
				random_sent++;
			end
		end

		req_ch.valid <= 1'b0;
		while (owed_responses.size() != 0) begin
			@(posedge clk);
		end
		// keep clocking so any stray response is caught
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
